[design/mbrfc_pkg.sv]
package mbrfc_pkg;

    localparam int MAX_FRAME_BYTES = 255;
    localparam int HDR_BYTES       = 7;
    localparam int CNT_W           = 9;
    localparam int Q_DEPTH         = 2;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int Q_CW            = $clog2(Q_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX       = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] LEN_EXCEPTION = 9'd5;
    localparam logic [CNT_W-1:0] LEN_FIXED     = 9'd8;
    localparam logic [CNT_W-1:0] LEN_MULTI_HDR = 9'd9;
    localparam logic [CNT_W-1:0] LEN_CRC       = 9'd2;
    localparam logic [CNT_W-1:0] LEN_MAX       = CNT_W'(MAX_FRAME_BYTES);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_NOTE = 1'b1;

    localparam logic [7:0] FC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

    typedef enum logic [1:0] {
        FT_INVALID   = 2'd0,
        FT_REQUEST   = 2'd1,
        FT_RESPONSE  = 2'd2,
        FT_EXCEPTION = 2'd3
    } t_frame_type;

    // One queue word: either a finished frame or a request note. A note
    // reuses the header slots: address, function, register high, register low.
    typedef struct packed {
        logic                           is_note;
        logic [CNT_W-1:0]               len;
        logic                           crc_ok;
        logic [HDR_BYTES-1:0][7:0]      hdr;
    } t_q_entry;

    typedef struct packed {
        logic [1:0]  frame_type;
        logic [7:0]  device_address;
        logic [7:0]  function_code;
        logic [15:0] register_start;
        logic [15:0] register_count;
        logic [15:0] write_value;
        logic [7:0]  data_length;
        logic [7:0]  exception_code;
        logic [7:0]  data_offset;
    } t_result;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[design/mbrfc_ifs.sv]
interface mbrfc_in_if;
    import mbrfc_pkg::*;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [7:0]  note_address;
    logic [7:0]  note_function;
    logic [15:0] note_register;

    modport source (output valid, cmd, frame_byte, last_byte, note_address, note_function,
                    note_register, input ready);
    modport sink (input valid, cmd, frame_byte, last_byte, note_address, note_function,
                  note_register, output ready);
endinterface

interface mbrfc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_type;
    logic [7:0]  device_address;
    logic [7:0]  function_code;
    logic [15:0] register_start;
    logic [15:0] register_count;
    logic [15:0] write_value;
    logic [7:0]  data_length;
    logic [7:0]  exception_code;
    logic [7:0]  data_offset;

    modport source (output valid, frame_type, device_address, function_code, register_start,
                    register_count, write_value, data_length, exception_code, data_offset,
                    input ready);
    modport sink (input valid, frame_type, device_address, function_code, register_start,
                  register_count, write_value, data_length, exception_code, data_offset,
                  output ready);
endinterface

interface mbrfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[design/mbrfc_front.sv]
module mbrfc_front
    import mbrfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mbrfc_in_if.sink          i_in,
    input  t_q_status         i_q_status,
    output logic              o_push,
    output t_q_entry          o_entry
);

    logic [CNT_W-1:0]          r_count, n_count;
    logic [15:0]               r_crc, n_crc;
    logic [HDR_BYTES-1:0][7:0] r_hdr, n_hdr;
    logic                      accept;
    logic [15:0]               crc_next;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign crc_next   = crc_byte(r_crc, i_in.frame_byte);

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        n_hdr   = r_hdr;
        o_push  = 1'b0;
        o_entry = '0;
        if (accept) begin
            if (i_in.cmd == CMD_NOTE) begin
                o_push         = 1'b1;
                o_entry.is_note = 1'b1;
                o_entry.hdr[0] = i_in.note_address;
                o_entry.hdr[1] = i_in.note_function;
                o_entry.hdr[2] = i_in.note_register[15:8];
                o_entry.hdr[3] = i_in.note_register[7:0];
            end else begin
                if (r_count < CNT_W'(HDR_BYTES)) begin
                    n_hdr[r_count[$clog2(HDR_BYTES)-1:0]] = i_in.frame_byte;
                end
                n_crc = crc_next;
                if (r_count != CNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
                if (i_in.last_byte) begin
                    o_push         = 1'b1;
                    o_entry.len    = n_count;
                    o_entry.crc_ok = (crc_next == 16'h0000);
                    o_entry.hdr    = n_hdr;
                    n_count        = '0;
                    n_crc          = CRC_INIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            r_count <= n_count;
            r_crc   <= n_crc;
        end
        r_hdr <= n_hdr;
    end

endmodule

[design/mbrfc_queue.sv]
module mbrfc_queue
    import mbrfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_q_entry  o_head
);

    t_q_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr;
    logic [Q_AW-1:0]   r_rd, n_rd;
    logic [Q_CW-1:0]   r_cnt, n_cnt;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[design/mbrfc_back.sv]
module mbrfc_back
    import mbrfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_q_entry   i_head,
    output logic       o_pop,
    mbrfc_cfg_if.sink  i_cfg,
    mbrfc_out_if.source o_out
);

    logic [7:0]  r_bcast;
    logic [7:0]  r_pend_addr, n_pend_addr;
    logic [7:0]  r_pend_func, n_pend_func;
    logic [15:0] r_pend_reg, n_pend_reg;
    logic        r_valid, n_valid;
    t_result     r_res, n_res;

    t_result          res;
    t_frame_type      ft;
    logic             ok_single;
    logic             pend_match;
    logic [CNT_W-1:0] len;
    logic [15:0]      hdr_reg;
    logic [15:0]      hdr_cnt;

    assign o_pop       = !i_q_status.empty && (!r_valid || o_out.ready);
    assign i_cfg.ready = 1'b1;
    assign len         = i_head.len;
    assign hdr_reg     = {i_head.hdr[2], i_head.hdr[3]};
    assign hdr_cnt     = {i_head.hdr[4], i_head.hdr[5]};

    always_comb begin
        res        = '0;
        ft         = FT_INVALID;
        ok_single  = 1'b0;
        pend_match = 1'b0;
        if (len > LEN_MAX) begin
            ft = FT_INVALID;
        end else if (len == LEN_EXCEPTION) begin
            if (i_head.crc_ok) begin
                ft                 = FT_EXCEPTION;
                res.device_address = i_head.hdr[0];
                res.function_code  = i_head.hdr[1];
                res.exception_code = i_head.hdr[2];
            end
        end else if (len >= LEN_FIXED) begin
            res.device_address = i_head.hdr[0];
            res.function_code  = i_head.hdr[1];
            if (i_head.crc_ok) begin
                unique case (i_head.hdr[1])
                    FC_READ_HOLDING, FC_READ_INPUT: begin
                        if (len == LEN_FIXED) begin
                            ft                 = FT_REQUEST;
                            res.register_start = hdr_reg;
                            res.register_count = hdr_cnt;
                        end else begin
                            res.data_length = i_head.hdr[2];
                            if ({1'b0, i_head.hdr[2]} == len - LEN_EXCEPTION) begin
                                ft = FT_RESPONSE;
                            end
                        end
                    end
                    FC_WRITE_SINGLE: begin
                        if (len == LEN_FIXED) begin
                            ok_single          = 1'b1;
                            res.register_start = hdr_reg;
                            res.register_count = 16'd1;
                            res.write_value    = hdr_cnt;
                        end
                    end
                    FC_WRITE_MULTI: begin
                        res.register_start = hdr_reg;
                        res.register_count = hdr_cnt;
                        if (len == LEN_FIXED) begin
                            ft = FT_RESPONSE;
                        end else begin
                            res.data_length = i_head.hdr[6];
                            if ({1'b0, i_head.hdr[6]} == len - LEN_MULTI_HDR) begin
                                ft = FT_REQUEST;
                            end
                        end
                    end
                    default: ft = FT_INVALID;
                endcase

                if ((ft != FT_INVALID || ok_single) && res.data_length != 8'd0) begin
                    res.data_offset = 8'(len - {1'b0, res.data_length} - LEN_CRC);
                end

                pend_match = (i_head.hdr[0] == r_pend_addr) && (i_head.hdr[1] == r_pend_func);
                if (ok_single) begin
                    ft = (pend_match && i_head.hdr[0] != r_bcast) ? FT_RESPONSE : FT_REQUEST;
                end else if (ft == FT_RESPONSE && pend_match
                             && (i_head.hdr[1] == FC_READ_HOLDING
                                 || i_head.hdr[1] == FC_READ_INPUT)) begin
                    // A read response carries no register number; take it from the request.
                    res.register_start = r_pend_reg;
                end
            end
        end
        res.frame_type = ft;
    end

    always_comb begin
        n_pend_addr = r_pend_addr;
        n_pend_func = r_pend_func;
        n_pend_reg  = r_pend_reg;
        n_valid     = r_valid && !o_out.ready;
        n_res       = r_res;
        if (o_pop) begin
            if (i_head.is_note) begin
                n_pend_addr = i_head.hdr[0];
                n_pend_func = i_head.hdr[1];
                n_pend_reg  = hdr_reg;
            end else begin
                n_valid = 1'b1;
                n_res   = res;
                priority if (res.frame_type == FT_REQUEST) begin
                    n_pend_addr = res.device_address;
                    n_pend_func = res.function_code;
                    n_pend_reg  = res.register_start;
                end else if (res.frame_type == FT_RESPONSE) begin
                    n_pend_addr = '0;
                    n_pend_func = '0;
                    n_pend_reg  = '0;
                end else begin
                    n_pend_addr = r_pend_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcast     <= '0;
            r_pend_addr <= '0;
            r_pend_func <= '0;
            r_pend_reg  <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_bcast <= i_cfg.data;
            end
            r_pend_addr <= n_pend_addr;
            r_pend_func <= n_pend_func;
            r_pend_reg  <= n_pend_reg;
            r_valid     <= n_valid;
        end
        r_res <= n_res;
    end

    assign o_out.valid          = r_valid;
    assign o_out.frame_type     = r_res.frame_type;
    assign o_out.device_address = r_res.device_address;
    assign o_out.function_code  = r_res.function_code;
    assign o_out.register_start = r_res.register_start;
    assign o_out.register_count = r_res.register_count;
    assign o_out.write_value    = r_res.write_value;
    assign o_out.data_length    = r_res.data_length;
    assign o_out.exception_code = r_res.exception_code;
    assign o_out.data_offset    = r_res.data_offset;

endmodule

[design/modbus_rtu_frame_classifier_unit.sv]
// Modbus RTU frame classifier.
// i_in takes one word per cycle while ready is high: a received frame byte
// (cmd 0, last_byte ends the frame) or a note of a request just sent (cmd 1).
// The CRC-16 and the first seven header bytes are built as the bytes arrive;
// each frame gives exactly one word on o_out, taken on the byte marked last.
// i_cfg writes the broadcast address; it is always ready and should only be
// written while no frame is in flight.
// The queue entry is written at the edge that accepts a frame's last byte,
// and the classifier loads the output register from the queue head. Throughput
// is one input word per cycle while the queue has room; the front end
// and the classifier are joined by a two-entry queue, and the classifier
// retires one queue entry per cycle while o_out is free. When o_out stalls,
// its word holds, the queue fills, and i_in.ready drops once the queue is
// full; mid-frame bytes keep flowing until then.
// Reset (synchronous, active low) clears the byte count, sets the CRC to
// 0xFFFF, clears the pending request and the broadcast address, and empties
// the queue and the output register.
module modbus_rtu_frame_classifier_unit
    import mbrfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    mbrfc_in_if.sink     i_in,
    mbrfc_cfg_if.sink    i_cfg,
    mbrfc_out_if.source  o_out
);

    logic      push;
    logic      pop;
    t_q_entry  entry;
    t_q_entry  head;
    t_q_status q_status;

    mbrfc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (entry)
    );

    mbrfc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    mbrfc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head),
        .o_pop      (pop),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

[design/mbrfc_checker.sv]
module mbrfc_checker
    import mbrfc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_frame_type,
    input logic [7:0]  i_function_code,
    input logic [15:0] i_register_count,
    input logic [15:0] i_write_value,
    input logic [7:0]  i_data_length,
    input logic [7:0]  i_exception_code,
    input logic [7:0]  i_data_offset
);

    // No result can appear in the cycle right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_type)
            && $stable(i_register_count))
        else $error("stalled result changed");

    // An exception frame carries only address, function and exception code.
    a_exc_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_frame_type == FT_EXCEPTION |->
            i_register_count == 16'd0 && i_data_length == 8'd0 && i_data_offset == 8'd0)
        else $error("exception result has frame fields set");

    a_exc_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_exception_code != 8'd0 |-> i_frame_type == FT_EXCEPTION)
        else $error("exception code outside an exception result");

    a_write_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_write_value != 16'd0 |-> i_function_code == FC_WRITE_SINGLE)
        else $error("write value outside a write-single result");

endmodule

bind modbus_rtu_frame_classifier_unit mbrfc_checker u_mbrfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_frame_type     (o_out.frame_type),
    .i_function_code  (o_out.function_code),
    .i_register_count (o_out.register_count),
    .i_write_value    (o_out.write_value),
    .i_data_length    (o_out.data_length),
    .i_exception_code (o_out.exception_code),
    .i_data_offset    (o_out.data_offset)
);
